@@ hw/rtl/pals_pkg.sv @@
// Shared widths, codes and control types of the per-address link statistics table.
`default_nettype none

package pals_pkg;

  // Fixed widths of the item and result fields.
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 48;
  localparam int HOP_W      = 8;
  localparam int SLOT_W     = 4;
  localparam int BIN_SEL_W  = 4;
  localparam int STATUS_W   = 3;
  localparam int CNT_OUT_W  = 32;
  localparam int MARK_OUT_W = 5;

  // Default sizing of the table.
  localparam int ENTRIES_DEF     = 16;
  localparam int HOP_BINS_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Reset value of the starting highest-hop mark.
  localparam logic [MARK_OUT_W-1:0] INIT_HOP_RESET = 5'd4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TX   = 2'd0;
  localparam logic [OP_W-1:0] OP_RX   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // Which send counter a transmit report bumps.
  localparam logic [1:0] TX_FAIL   = 2'd0;
  localparam logic [1:0] TX_OK     = 2'd1;
  localparam logic [1:0] TX_RESEND = 2'd2;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic       clear;      // clearing pass: zero one histogram word
    logic       look;       // match cycle: read the histogram word
    logic       commit;     // update cycle with a free output register
    logic       sel_valid;  // some slot is selected for this item
    logic       report;     // selected slot is modified
    logic       new_entry;  // selected slot is taken for a new address
    logic       rx;         // receive report
    logic [1:0] tx_code;    // send counter of a transmit report
  } pals_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pals_cell.sv @@
// One slot of the link statistics row: address, counters, hop mark and hop histogram.
`default_nettype none

module pals_cell #(
  parameter int ENTRIES     = 16,
  parameter int HOP_BINS    = 16,
  parameter int COUNT_WIDTH = 32,
  parameter int INDEX       = 0,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int BW = (HOP_BINS > 1) ? $clog2(HOP_BINS) : 1,
  localparam int MW = $clog2(HOP_BINS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pals_pkg::pals_ctl_t             ctl,
  input  logic [pals_pkg::ADDR_W-1:0]     cmp_addr,
  input  logic [BW-1:0]                   bin_idx,
  input  logic [BW-1:0]                   clear_idx,
  input  logic [MW-1:0]                   hop,
  input  logic [MW-1:0]                   start_mark,
  input  logic [IW-1:0]                   sel_slot,
  input  logic                            hit_in,
  input  logic [IW-1:0]                   hit_idx_in,
  input  logic [pals_pkg::ADDR_W-1:0]     addr_in,
  input  logic [COUNT_WIDTH-1:0]          failed_in,
  input  logic [COUNT_WIDTH-1:0]          ok_in,
  input  logic [COUNT_WIDTH-1:0]          resent_in,
  input  logic [COUNT_WIDTH-1:0]          received_in,
  input  logic [COUNT_WIDTH-1:0]          bin_in,
  input  logic [MW-1:0]                   mark_in,
  output logic                            hit_out,
  output logic [IW-1:0]                   hit_idx_out,
  output logic [pals_pkg::ADDR_W-1:0]     addr_out,
  output logic [COUNT_WIDTH-1:0]          failed_out,
  output logic [COUNT_WIDTH-1:0]          ok_out,
  output logic [COUNT_WIDTH-1:0]          resent_out,
  output logic [COUNT_WIDTH-1:0]          received_out,
  output logic [COUNT_WIDTH-1:0]          bin_out,
  output logic [MW-1:0]                   mark_out
);
  import pals_pkg::*;

  logic                   valid;
  logic [ADDR_W-1:0]      addr;
  logic [COUNT_WIDTH-1:0] failed;
  logic [COUNT_WIDTH-1:0] ok_cnt;
  logic [COUNT_WIDTH-1:0] resent;
  logic [COUNT_WIDTH-1:0] received;
  logic [MW-1:0]          mark;
  logic [COUNT_WIDTH-1:0] hist_mem [HOP_BINS];
  logic [COUNT_WIDTH-1:0] rd_data;

  logic                   match;
  logic                   selected;
  logic                   update;
  logic [ADDR_W-1:0]      addr_next;
  logic [COUNT_WIDTH-1:0] failed_next;
  logic [COUNT_WIDTH-1:0] ok_next;
  logic [COUNT_WIDTH-1:0] resent_next;
  logic [COUNT_WIDTH-1:0] received_next;
  logic [COUNT_WIDTH-1:0] bin_next;
  logic [MW-1:0]          mark_next;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  assign match    = valid && (addr == cmp_addr);
  assign selected = ctl.sel_valid && (sel_slot == IW'(INDEX));
  assign update   = ctl.commit && selected && ctl.report;

  // Values after this item's update; a newly taken slot starts from zero counters.
  always_comb begin
    addr_next     = ctl.new_entry ? cmp_addr : addr;
    failed_next   = ctl.new_entry ? '0 : failed;
    ok_next       = ctl.new_entry ? '0 : ok_cnt;
    resent_next   = ctl.new_entry ? '0 : resent;
    received_next = ctl.new_entry ? '0 : received;
    mark_next     = ctl.new_entry ? start_mark : mark;
    bin_next      = rd_data;
    if (ctl.report) begin
      if (ctl.rx) begin
        received_next = bump(received_next);
        bin_next      = bump(rd_data);
        if (hop > mark_next) begin
          mark_next = hop;
        end
      end else begin
        case (ctl.tx_code)
          TX_RESEND: resent_next = bump(resent_next);
          TX_FAIL:   failed_next = bump(failed_next);
          default:   ok_next     = bump(ok_next);
        endcase
      end
    end
  end

  // Hand the match and the selected slot's values on to the next cell.
  assign hit_out      = hit_in | match;
  assign hit_idx_out  = hit_idx_in | (match ? IW'(INDEX) : '0);
  assign addr_out     = addr_in | (selected ? addr_next : '0);
  assign failed_out   = failed_in | (selected ? failed_next : '0);
  assign ok_out       = ok_in | (selected ? ok_next : '0);
  assign resent_out   = resent_in | (selected ? resent_next : '0);
  assign received_out = received_in | (selected ? received_next : '0);
  assign bin_out      = bin_in | (selected ? bin_next : '0);
  assign mark_out     = mark_in | (selected ? mark_next : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (update && ctl.new_entry) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      addr     <= addr_next;
      failed   <= failed_next;
      ok_cnt   <= ok_next;
      resent   <= resent_next;
      received <= received_next;
      mark     <= mark_next;
    end
  end

  // Histogram memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hist_mem[clear_idx] <= '0;
    end else if (update && ctl.rx) begin
      hist_mem[bin_idx] <= bin_next;
    end
    if (ctl.look) begin
      rd_data <= hist_mem[bin_idx];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/per_address_link_stats_table.sv @@
// An accepted item passes an address match across the cell row, then a
// read-modify-write of the selected slot's histogram memory and counters, which
// waits for a free output register and loads the result into it, held until taken.
// A new item is taken during that update, but not during the match.
// Reset: synchronous and active high; a clearing pass then zeroes every cell's
// histogram in parallel with in_ready low; configuration writes are taken throughout.
`default_nettype none

module per_address_link_stats_table #(
  parameter int ENTRIES     = pals_pkg::ENTRIES_DEF,
  parameter int HOP_BINS    = pals_pkg::HOP_BINS_DEF,
  parameter int COUNT_WIDTH = pals_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [pals_pkg::MARK_OUT_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pals_pkg::OP_W-1:0]           operation,
  input  logic [pals_pkg::ADDR_W-1:0]         address,
  input  logic                                success,
  input  logic                                retransmit,
  input  logic [pals_pkg::HOP_W-1:0]          hop_count,
  input  logic [pals_pkg::SLOT_W-1:0]         read_slot,
  input  logic [pals_pkg::BIN_SEL_W-1:0]      read_bin,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pals_pkg::STATUS_W-1:0]       status,
  output logic [pals_pkg::SLOT_W-1:0]         slot,
  output logic [pals_pkg::ADDR_W-1:0]         entry_address,
  output logic [pals_pkg::CNT_OUT_W-1:0]      sent_failed,
  output logic [pals_pkg::CNT_OUT_W-1:0]      sent_ok,
  output logic [pals_pkg::CNT_OUT_W-1:0]      resent,
  output logic [pals_pkg::CNT_OUT_W-1:0]      received,
  output logic [pals_pkg::CNT_OUT_W-1:0]      bin_count,
  output logic [pals_pkg::MARK_OUT_W-1:0]     highest_hop
);
  import pals_pkg::*;

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW  = $clog2(ENTRIES + 1);
  localparam int BW  = (HOP_BINS > 1) ? $clog2(HOP_BINS) : 1;
  localparam int MW  = $clog2(HOP_BINS + 1);
  localparam int SMW = (MW > MARK_OUT_W) ? MW : MARK_OUT_W;
  localparam int CXW = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

  // Sequencer states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic [BW-1:0]         clear_idx;
  logic [UW-1:0]         used_slots;
  logic [MARK_OUT_W-1:0] initial_hop_bins;

  // The accepted item, held until its update is committed.
  logic [OP_W-1:0]       req_op;
  logic [ADDR_W-1:0]     req_addr;
  logic                  req_success;
  logic                  req_retransmit;
  logic [HOP_W-1:0]      req_hop;
  logic [SLOT_W-1:0]     req_read_slot;
  logic [BIN_SEL_W-1:0]  req_read_bin;

  // Decision made in the match cycle.
  logic [STATUS_W-1:0]   dec_status;
  logic [SLOT_W-1:0]     dec_slot;
  logic [IW-1:0]         dec_sel;
  logic                  dec_sel_valid;
  logic                  dec_new;
  logic                  dec_report;
  logic                  dec_bin_keep;

  logic [STATUS_W-1:0]   look_status;
  logic [SLOT_W-1:0]     look_slot;
  logic [IW-1:0]         look_sel;
  logic                  look_sel_valid;
  logic                  look_new;
  logic                  look_report;
  logic                  look_bin_keep;

  logic                  accept;
  logic                  out_free;
  logic                  is_rx;
  logic                  bad_hop;
  logic                  read_in_use;
  logic                  read_bin_ok;
  logic                  table_full;
  logic [BW-1:0]         bin_idx;
  logic [MW-1:0]         hop_mark_in;
  logic [SMW-1:0]        start_wide;
  logic [MW-1:0]         start_mark;
  pals_ctl_t             ctl;

  // Links between neighboring cells; link 0 enters the first cell.
  logic                   hit_c      [ENTRIES+1];
  logic [IW-1:0]          hit_idx_c  [ENTRIES+1];
  logic [ADDR_W-1:0]      addr_c     [ENTRIES+1];
  logic [COUNT_WIDTH-1:0] failed_c   [ENTRIES+1];
  logic [COUNT_WIDTH-1:0] ok_c       [ENTRIES+1];
  logic [COUNT_WIDTH-1:0] resent_c   [ENTRIES+1];
  logic [COUNT_WIDTH-1:0] received_c [ENTRIES+1];
  logic [COUNT_WIDTH-1:0] bin_c      [ENTRIES+1];
  logic [MW-1:0]          mark_c     [ENTRIES+1];

  logic [CXW-1:0]        failed_x;
  logic [CXW-1:0]        ok_x;
  logic [CXW-1:0]        resent_x;
  logic [CXW-1:0]        received_x;
  logic [CXW-1:0]        bin_x;
  logic [SMW-1:0]        mark_x;

  // The output register parts the two sides: a new item is taken in the update
  // cycle as long as the finished result can move into the output register.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept   = in_valid && in_ready;

  assign is_rx       = (req_op == OP_RX);
  assign bad_hop     = is_rx && ((req_hop == '0) || (int'(req_hop) > HOP_BINS));
  assign read_in_use = (req_op == OP_READ) && (int'(req_read_slot) < int'(used_slots));
  assign read_bin_ok = int'(req_read_bin) < HOP_BINS;
  assign table_full  = (used_slots == UW'(ENTRIES));

  // Histogram word of this item: the reported hop's bin, or the bin asked for.
  assign bin_idx     = is_rx ? BW'(req_hop - 8'd1) : BW'(req_read_bin);
  assign hop_mark_in = MW'(req_hop);

  // The configured starting mark is clamped to the range of the histogram.
  always_comb begin
    start_wide = SMW'(initial_hop_bins);
    if (start_wide == '0) begin
      start_wide = SMW'(1);
    end else if (start_wide > SMW'(HOP_BINS)) begin
      start_wide = SMW'(HOP_BINS);
    end
    start_mark = MW'(start_wide);
  end

  // Match-cycle decision. Reads and operation three never change state; a bad hop,
  // or a full table without a match, leaves every slot alone; otherwise the matching
  // slot, or the next free one, is selected. Slots fill in order, so the next free
  // slot is the fill count and a read slot is in use exactly when below that count.
  always_comb begin
    look_status    = ST_EMPTY;
    look_slot      = req_read_slot;
    look_sel       = IW'(req_read_slot);
    look_sel_valid = 1'b0;
    look_new       = 1'b0;
    look_report    = 1'b0;
    look_bin_keep  = 1'b0;
    if ((req_op != OP_TX) && (req_op != OP_RX)) begin
      if (read_in_use) begin
        look_status    = ST_HIT;
        look_sel_valid = 1'b1;
        look_bin_keep  = read_bin_ok;
      end
    end else if (bad_hop) begin
      look_status = ST_BAD;
      look_slot   = '0;
    end else if (hit_c[ENTRIES]) begin
      look_status    = ST_HIT;
      look_sel       = hit_idx_c[ENTRIES];
      look_slot      = SLOT_W'(hit_idx_c[ENTRIES]);
      look_sel_valid = 1'b1;
      look_report    = 1'b1;
      look_bin_keep  = is_rx;
    end else if (table_full) begin
      look_status = ST_FULL;
      look_slot   = '0;
    end else begin
      look_status    = ST_NEW;
      look_sel       = IW'(used_slots);
      look_slot      = SLOT_W'(used_slots);
      look_sel_valid = 1'b1;
      look_new       = 1'b1;
      look_report    = 1'b1;
      look_bin_keep  = is_rx;
    end
  end

  always_comb begin
    ctl.clear     = (state == S_CLEAR);
    ctl.look      = (state == S_LOOK);
    ctl.commit    = (state == S_DONE) && out_free;
    ctl.sel_valid = dec_sel_valid;
    ctl.report    = dec_report;
    ctl.new_entry = dec_new;
    ctl.rx        = is_rx;
    if (req_retransmit) begin
      ctl.tx_code = TX_RESEND;
    end else if (!req_success) begin
      ctl.tx_code = TX_FAIL;
    end else begin
      ctl.tx_code = TX_OK;
    end
  end

  // The row of cells. Each cell ORs its match and, when selected, its updated
  // values into the links it passes to its right-hand neighbor.
  assign hit_c[0]      = 1'b0;
  assign hit_idx_c[0]  = '0;
  assign addr_c[0]     = '0;
  assign failed_c[0]   = '0;
  assign ok_c[0]       = '0;
  assign resent_c[0]   = '0;
  assign received_c[0] = '0;
  assign bin_c[0]      = '0;
  assign mark_c[0]     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pals_cell #(
      .ENTRIES     (ENTRIES),
      .HOP_BINS    (HOP_BINS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .cmp_addr     (req_addr),
      .bin_idx      (bin_idx),
      .clear_idx    (clear_idx),
      .hop          (hop_mark_in),
      .start_mark   (start_mark),
      .sel_slot     (dec_sel),
      .hit_in       (hit_c[i]),
      .hit_idx_in   (hit_idx_c[i]),
      .addr_in      (addr_c[i]),
      .failed_in    (failed_c[i]),
      .ok_in        (ok_c[i]),
      .resent_in    (resent_c[i]),
      .received_in  (received_c[i]),
      .bin_in       (bin_c[i]),
      .mark_in      (mark_c[i]),
      .hit_out      (hit_c[i+1]),
      .hit_idx_out  (hit_idx_c[i+1]),
      .addr_out     (addr_c[i+1]),
      .failed_out   (failed_c[i+1]),
      .ok_out       (ok_c[i+1]),
      .resent_out   (resent_c[i+1]),
      .received_out (received_c[i+1]),
      .bin_out      (bin_c[i+1]),
      .mark_out     (mark_c[i+1])
    );
  end

  // Counters are shown as their low bits, zero-extended when narrower.
  assign failed_x   = CXW'(failed_c[ENTRIES]);
  assign ok_x       = CXW'(ok_c[ENTRIES]);
  assign resent_x   = CXW'(resent_c[ENTRIES]);
  assign received_x = CXW'(received_c[ENTRIES]);
  assign bin_x      = CXW'(bin_c[ENTRIES]);
  assign mark_x     = SMW'(mark_c[ENTRIES]);

  // Control: sequencer, fill count, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clear_idx        <= '0;
      used_slots       <= '0;
      out_valid        <= 1'b0;
      initial_hop_bins <= INIT_HOP_RESET;
    end else begin
      if (cfg_wr_en) begin
        initial_hop_bins <= cfg_wr_data;
      end
      // A committed result loads the output register; otherwise a taken one leaves it.
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clear_idx == BW'(HOP_BINS - 1)) begin
            state <= S_IDLE;
          end else begin
            clear_idx <= clear_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            if (dec_new) begin
              used_slots <= used_slots + 1'b1;
            end
            state <= accept ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: the held item, the match decision and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op         <= operation;
      req_addr       <= address;
      req_success    <= success;
      req_retransmit <= retransmit;
      req_hop        <= hop_count;
      req_read_slot  <= read_slot;
      req_read_bin   <= read_bin;
    end
    if (state == S_LOOK) begin
      dec_status    <= look_status;
      dec_slot      <= look_slot;
      dec_sel       <= look_sel;
      dec_sel_valid <= look_sel_valid;
      dec_new       <= look_new;
      dec_report    <= look_report;
      dec_bin_keep  <= look_bin_keep;
    end
    if (ctl.commit) begin
      status        <= dec_status;
      slot          <= dec_slot;
      entry_address <= addr_c[ENTRIES];
      sent_failed   <= failed_x[CNT_OUT_W-1:0];
      sent_ok       <= ok_x[CNT_OUT_W-1:0];
      resent        <= resent_x[CNT_OUT_W-1:0];
      received      <= received_x[CNT_OUT_W-1:0];
      bin_count     <= dec_bin_keep ? bin_x[CNT_OUT_W-1:0] : '0;
      highest_hop   <= mark_x[MARK_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pals_checker.sv @@
// Port-level checks of the link statistics table and their binding to it.
`default_nettype none

module pals_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pals_pkg::STATUS_W-1:0]       status,
  input logic [pals_pkg::SLOT_W-1:0]         slot,
  input logic [pals_pkg::ADDR_W-1:0]         entry_address,
  input logic [pals_pkg::CNT_OUT_W-1:0]      sent_failed,
  input logic [pals_pkg::CNT_OUT_W-1:0]      sent_ok,
  input logic [pals_pkg::CNT_OUT_W-1:0]      resent,
  input logic [pals_pkg::CNT_OUT_W-1:0]      received,
  input logic [pals_pkg::CNT_OUT_W-1:0]      bin_count,
  input logic [pals_pkg::MARK_OUT_W-1:0]     highest_hop
);
  import pals_pkg::*;

  // A refused, full-table or empty-slot result carries no slot contents.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_BAD || status == ST_EMPTY) |->
      entry_address == '0 && sent_failed == '0 && sent_ok == '0 && resent == '0 &&
      received == '0 && bin_count == '0 && highest_hop == '0)
    else $error("rejected item shows slot contents");

  // Each item occupies the match cycle, so no item is taken right after another.
  a_one_per_two: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in the match cycle");

  // Without an update cycle pending, a taken result is not followed by another.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !in_ready |=> !out_valid)
    else $error("result appeared without an update cycle");

  // A result waiting for the consumer stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(slot) && $stable(entry_address) &&
      $stable(sent_ok) && $stable(bin_count))
    else $error("waiting result changed");

endmodule

bind per_address_link_stats_table pals_checker u_pals_checker (.*);

`default_nettype wire
